[design/dfs_pkg.sv]
// dfs_pkg: shared types, magic constants and the classification function
// for the data format sniffer. No dependencies.
`default_nettype none

package dfs_pkg;

    typedef enum logic [3:0] {
        FMT_UNKNOWN = 4'd0,
        FMT_GLYPH   = 4'd1,
        FMT_JSON    = 4'd2,
        FMT_XML     = 4'd3,
        FMT_TAR     = 4'd4,
        FMT_ZIP     = 4'd5,
        FMT_HDF5    = 4'd6,
        FMT_PARQUET = 4'd7,
        FMT_MSGPACK = 4'd8
    } t_format;

    localparam int COUNT_W = 9;
    localparam int LEN_W   = COUNT_W + 1;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = 9'd511;
    localparam logic [COUNT_W-1:0] TAR_OFFSET = 9'd257;
    localparam logic [LEN_W-1:0]   TAR_MIN    = 10'd263;

    // little-endian packing: byte 0 of the buffer in the low bits
    localparam logic [39:0] MAGIC_XML  = 40'h6C6D783F3C;
    localparam logic [31:0] MAGIC_ZIP  = 32'h04034B50;
    localparam logic [63:0] MAGIC_HDF5 = 64'h0A1A0A0D46444889;
    localparam logic [31:0] MAGIC_PAR1 = 32'h31524150;

    localparam logic [7:0] MAGIC_USTAR [5] = '{8'h75, 8'h73, 8'h74, 8'h61, 8'h72};

    // buffer status as it stands once the current word is included
    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [63:0]      lead;
        logic             nonspace;
        logic             json_start;
        logic             ustar_ok;
    } t_buf_status;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D);
    endfunction

    function automatic logic opens_json(input logic [7:0] c);
        return (c == 8'h7B) || (c == 8'h5B) || (c == 8'h22) || (c == 8'h2D) ||
               ((c >= 8'h30) && (c <= 8'h39)) ||
               (c == 8'h74) || (c == 8'h66) || (c == 8'h6E);
    endfunction

    function automatic t_format classify(input t_buf_status s,
                                         input logic [LEN_W-1:0] glyph_len);
        logic [7:0] first;
        t_format    code;
        first = s.lead[7:0];
        if ((s.len == glyph_len) && ((first <= 8'h25) || (first == 8'hFF))) begin
            code = FMT_GLYPH;
        end else if (s.nonspace && s.json_start) begin
            code = FMT_JSON;
        end else if ((s.len >= 10'd5) && (s.lead[39:0] == MAGIC_XML)) begin
            code = FMT_XML;
        end else if ((s.len >= TAR_MIN) && s.ustar_ok) begin
            code = FMT_TAR;
        end else if ((s.len >= 10'd4) && (s.lead[31:0] == MAGIC_ZIP)) begin
            code = FMT_ZIP;
        end else if ((s.len >= 10'd8) && (s.lead == MAGIC_HDF5)) begin
            code = FMT_HDF5;
        end else if ((s.len >= 10'd4) && (s.lead[31:0] == MAGIC_PAR1)) begin
            code = FMT_PARQUET;
        end else if ((first == 8'hC0) || (first == 8'hC2) || (first == 8'hC3) ||
                     (first[7:6] == 2'b10)) begin
            code = FMT_MSGPACK;
        end else begin
            code = FMT_UNKNOWN;
        end
        return code;
    endfunction

endpackage

`default_nettype wire

[design/dfs_track.sv]
// dfs_track: per-buffer state (length, leading bytes, json and ustar flags)
// Depends on dfs_pkg.
`default_nettype none

module dfs_track (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_accept,
    input  wire logic [7:0]         i_byte_value,
    input  wire logic               i_last_byte,
    output dfs_pkg::t_buf_status    o_status
);

    logic [dfs_pkg::COUNT_W-1:0] r_byte_count, n_byte_count;
    logic [63:0]                 r_leading_bytes, n_leading_bytes;
    logic                        r_nonspace_found, n_nonspace_found;
    logic                        r_json_start, n_json_start;
    logic                        r_ustar_match, n_ustar_match;
    logic [dfs_pkg::COUNT_W-1:0] ustar_off;

    assign ustar_off = r_byte_count - dfs_pkg::TAR_OFFSET;

    always_comb begin
        n_leading_bytes = r_leading_bytes;
        for (int i = 0; i < 8; i++) begin
            if (r_byte_count == dfs_pkg::COUNT_W'(i)) begin
                n_leading_bytes[8*i +: 8] = i_byte_value;
            end
        end

        n_nonspace_found = r_nonspace_found;
        n_json_start     = r_json_start;
        if (!r_nonspace_found && !dfs_pkg::is_space(i_byte_value)) begin
            n_nonspace_found = 1'b1;
            n_json_start     = dfs_pkg::opens_json(i_byte_value);
        end

        n_ustar_match = r_ustar_match;
        if ((r_byte_count >= dfs_pkg::TAR_OFFSET) &&
            (r_byte_count < dfs_pkg::TAR_OFFSET + 9'd5)) begin
            if (i_byte_value != dfs_pkg::MAGIC_USTAR[ustar_off[2:0]]) begin
                n_ustar_match = 1'b0;
            end
        end

        n_byte_count = (r_byte_count == dfs_pkg::COUNT_MAX) ? r_byte_count
                                                             : r_byte_count + 9'd1;
    end

    assign o_status.len        = {1'b0, r_byte_count} + 10'd1;
    assign o_status.lead       = n_leading_bytes;
    assign o_status.nonspace   = n_nonspace_found;
    assign o_status.json_start = n_json_start;
    assign o_status.ustar_ok   = n_ustar_match;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_last_byte)) begin
            r_byte_count     <= '0;
            r_leading_bytes  <= '0;
            r_nonspace_found <= 1'b0;
            r_json_start     <= 1'b0;
            r_ustar_match    <= 1'b1;
        end else if (i_accept) begin
            r_byte_count     <= n_byte_count;
            r_leading_bytes  <= n_leading_bytes;
            r_nonspace_found <= n_nonspace_found;
            r_json_start     <= n_json_start;
            r_ustar_match    <= n_ustar_match;
        end
    end

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_last_byte) |=> (r_byte_count == '0 && r_ustar_match))
        else $error("buffer state not cleared after last word");

    a_json_needs_nonspace: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_json_start |-> r_nonspace_found)
        else $error("json flag set before any non-whitespace word");

    a_count_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && !i_last_byte && r_byte_count != dfs_pkg::COUNT_MAX)
            |=> (r_byte_count == $past(r_byte_count) + 9'd1))
        else $error("byte count did not advance");

endmodule

`default_nettype wire

[design/data_format_sniffer_core.sv]
// data_format_sniffer_core: guesses the serialization format of a buffer
// streamed one word per cycle. Depends on dfs_pkg and dfs_track.
// Throughput: one word per cycle; a new buffer may start right after a last word.
// Latency: the result is valid the cycle after the last word is accepted.
// Only a last word waits on a stalled result; other words keep flowing.
// Reset is synchronous, active low, and clears all buffer state and o_out_valid.
`default_nettype none

module data_format_sniffer_core #(
    parameter int GLYPH_LENGTH = 192
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_byte_value,
    input  wire logic       i_last_byte,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [3:0]      o_format_code
);

    logic                 in_acc;
    logic                 out_free;
    dfs_pkg::t_buf_status status;
    logic                 r_out_valid;
    dfs_pkg::t_format     r_code;

    // only a last word needs the result register
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = i_last_byte && !out_free;
    assign in_acc     = i_in_valid && !o_in_stall;

    dfs_track u_track (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_acc),
        .i_byte_value (i_byte_value),
        .i_last_byte  (i_last_byte),
        .o_status     (status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= in_acc && i_last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_last_byte) begin
            r_code <= dfs_pkg::classify(status, dfs_pkg::LEN_W'(GLYPH_LENGTH));
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_format_code = r_code;

    a_result_follows_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_last_byte) |=> o_out_valid)
        else $error("no result after last word");

    a_no_invented_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(in_acc && i_last_byte))
        else $error("result without a last word");

    a_code_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_format_code <= dfs_pkg::FMT_MSGPACK))
        else $error("format code out of range");

endmodule

`default_nettype wire
